[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files of the waypoint route sequencer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is high.
`define WRS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define WRS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/wrs_pkg.sv]
// ---------------------------------------------------------------------------
// wrs_pkg
// Types, widths and codes shared by the waypoint route sequencer modules.
// ---------------------------------------------------------------------------
package wrs_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int DEF_MAX_WAYPOINTS = 32;
   localparam int DEF_CHANGE_DELAY  = 10;

   // Fixed field widths.
   localparam int DIST_W    = 24;
   localparam int COUNT_W   = 6;
   localparam int MODE_W    = 2;
   localparam int OUT_IDX_W = 5;
   localparam int CSR_IDX_W = 2;

   // Register indices on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_ROUTE_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WAYPOINT_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REACH_RANGE    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_CHANGE    = 2'd3;

   // End-of-route behaviour codes.
   localparam logic [MODE_W-1:0] MODE_GO_HOME = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REPEAT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REVERSE = 2'd2;

   // Configuration registers as seen by the sequencing core.
   typedef struct packed {
      logic [MODE_W-1:0]  route_mode;
      logic [COUNT_W-1:0] waypoint_count;
      logic [DIST_W-1:0]  reach_range;
      logic               hold_before_change;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic                 reverse_active;
      logic                 change_pending;
      logic                 going_home;
      logic [OUT_IDX_W-1:0] waypoint_index;
   } result_type;

endpackage

[rtl/waypoint_route_sequencer_top.sv]
// ---------------------------------------------------------------------------
// waypoint_route_sequencer_top
// Waypoint route sequencer: stream in, stream out, register write port.
// ---------------------------------------------------------------------------
// The sequencer takes one navigation tick per clock cycle and returns one
// result per tick, in the cycle after the transfer that brought it in. The
// route state is updated in a single pass of compare and increment logic
// at the input transfer, and the new state is held in a result register;
// a tick is accepted whenever that register is empty or its result is
// being taken in the same cycle, so the rate is one item per cycle under
// a free-flowing output.
`include "assert_macros.svh"

module waypoint_route_sequencer_top
   import wrs_pkg::*;
#(
   parameter int MAX_WAYPOINTS = DEF_MAX_WAYPOINTS,
   parameter int CHANGE_DELAY  = DEF_CHANGE_DELAY
)(
   input  logic                 clock,
   input  logic                 reset,
   // Tick stream.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [31:0]          req_tdata,   // [23:0] waypoint_distance, [24] heading_home
   // Result stream.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [4:0] waypoint_index, [5] going_home,
                                             // [6] change_pending, [7] reverse_active
   // Register writes.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIST_W-1:0]    csr_data
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   result_type result_next;
   result_type rsp_data_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_xfer;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_ROUTE_MODE:     cfg_in.route_mode         = csr_data[MODE_W-1:0];
            REG_WAYPOINT_COUNT: cfg_in.waypoint_count     = csr_data[COUNT_W-1:0];
            REG_REACH_RANGE:    cfg_in.reach_range        = csr_data;
            REG_HOLD_CHANGE:    cfg_in.hold_before_change = csr_data[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.route_mode         <= MODE_GO_HOME;
         cfg_ff.waypoint_count     <= COUNT_W'(1);
         cfg_ff.reach_range        <= '0;
         cfg_ff.hold_before_change <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input side: a tick is taken while the result register can be refilled.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   wrs_core #(
      .MAX_WAYPOINTS (MAX_WAYPOINTS),
      .CHANGE_DELAY  (CHANGE_DELAY)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (req_xfer),
      .distance     (req_tdata[DIST_W-1:0]),
      .heading_home (req_tdata[DIST_W]),
      .cfg          (cfg_ff),
      .result_next  (result_next)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= result_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Every accepted tick leaves a result waiting in the next cycle.
   `WRS_ASSERT(a_xfer_gives_result, req_xfer |=> rsp_valid_ff, "accepted tick produced no result")
   // No result stands in the register straight after reset.
   `WRS_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid_ff, "result valid after reset")
   // A waiting result that is not taken blocks the input.
   `WRS_ASSERT(a_no_overwrite, (rsp_valid_ff && !rsp_tready) |-> !req_tready,
               "input accepted over a waiting result")

endmodule

[rtl/wrs_core.sv]
// ---------------------------------------------------------------------------
// wrs_core
// Route state registers and the next-state logic for one navigation tick.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wrs_core
   import wrs_pkg::*;
#(
   parameter int MAX_WAYPOINTS = DEF_MAX_WAYPOINTS,
   parameter int CHANGE_DELAY  = DEF_CHANGE_DELAY
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [DIST_W-1:0] distance,
   input  logic              heading_home,
   input  cfg_type           cfg,
   output result_type        result_next
);

   localparam int IDX_W = $clog2(MAX_WAYPOINTS);
   localparam int LEN_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
   localparam int CD_W  = $clog2(CHANGE_DELAY + 1);
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WAYPOINTS);
   localparam logic [CD_W-1:0]  DELAY   = CD_W'(CHANGE_DELAY);

   logic [IDX_W-1:0]  index_ff, index_in;
   logic              home_ff, home_in;
   logic              reverse_ff, reverse_in;
   logic              pending_ff, pending_in;
   logic [CD_W-1:0]   countdown_ff, countdown_in;
   logic [DIST_W-1:0] prev_dist_ff, prev_dist_in;

   logic [LEN_W-1:0]       count_ext;
   logic [LEN_W-1:0]       route_len;
   logic [LEN_W-1:0]       last_idx;
   logic [LEN_W-1:0]       index_ext;
   logic                   blocked;
   logic [IDX_W+OUT_IDX_W-1:0] index_wide;

   // Effective route length: zero counts as one, clamped to the table size.
   always_comb begin
      count_ext = LEN_W'(cfg.waypoint_count);
      if (count_ext == '0) begin
         route_len = LEN_W'(1);
      end else if (count_ext > MAX_LEN) begin
         route_len = MAX_LEN;
      end else begin
         route_len = count_ext;
      end
      last_idx  = route_len - LEN_W'(1);
      index_ext = LEN_W'(index_ff);
   end

   assign blocked = heading_home | home_ff;

   // Next state for one tick: countdown, reach detection and index change.
   always_comb begin
      index_in     = index_ff;
      home_in      = home_ff;
      reverse_in   = reverse_ff;
      pending_in   = pending_ff;
      countdown_in = countdown_ff;
      prev_dist_in = prev_dist_ff;

      if (pending_ff) begin
         if (countdown_ff != '0) begin
            countdown_in = countdown_ff - CD_W'(1);
         end else begin
            pending_in = 1'b0;
            if (!blocked) begin
               if (!reverse_ff) begin
                  // Forward pass.
                  if (index_ext >= last_idx) begin
                     if (cfg.route_mode == MODE_GO_HOME) begin
                        home_in = 1'b1;
                     end else if (cfg.route_mode == MODE_REPEAT) begin
                        index_in = '0;
                     end else begin
                        reverse_in = 1'b1;
                        if (index_ff != '0) begin
                           index_in = index_ff - IDX_W'(1);
                        end
                     end
                  end else begin
                     index_in = index_ff + IDX_W'(1);
                  end
               end else begin
                  // Backward pass.
                  if (index_ff == '0) begin
                     if (cfg.route_mode == MODE_REVERSE) begin
                        home_in = 1'b1;
                     end else begin
                        reverse_in = 1'b0;
                        if (last_idx != '0) begin
                           index_in = index_ff + IDX_W'(1);
                        end
                     end
                  end else begin
                     index_in = index_ff - IDX_W'(1);
                  end
               end
            end
         end
      end else if (!blocked) begin
         // Reached: inside the radius and moving away again.
         if ((distance < cfg.reach_range) && (prev_dist_ff < distance)) begin
            pending_in   = 1'b1;
            countdown_in = cfg.hold_before_change ? DELAY : '0;
         end else begin
            prev_dist_in = distance;
         end
      end
   end

   // State registers, updated once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= '0;
         home_ff      <= 1'b0;
         reverse_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         countdown_ff <= '0;
         prev_dist_ff <= '0;
      end else if (step) begin
         index_ff     <= index_in;
         home_ff      <= home_in;
         reverse_ff   <= reverse_in;
         pending_ff   <= pending_in;
         countdown_ff <= countdown_in;
         prev_dist_ff <= prev_dist_in;
      end
   end

   // The result carries the state after the tick.
   assign index_wide                 = {{OUT_IDX_W{1'b0}}, index_in};
   assign result_next.waypoint_index = index_wide[OUT_IDX_W-1:0];
   assign result_next.going_home     = home_in;
   assign result_next.change_pending = pending_in;
   assign result_next.reverse_active = reverse_in;

   // Going home is sticky until reset.
   `WRS_ASSERT(a_home_sticky, home_ff |=> home_ff, "going-home flag cleared")
   // Without a tick the index does not move.
   `WRS_ASSERT(a_index_hold, !step |=> $stable(index_ff), "index moved without a tick")
   // A running countdown keeps the change pending.
   `WRS_ASSERT(a_pending_hold, (step && pending_ff && (countdown_ff != '0)) |=> pending_ff,
               "pending change dropped before countdown expired")

endmodule
